// File: sv/lss_pkg.sv
// ---------------------------------------------------------------------------
// lss_pkg
// Shared types, codes and sizes for the LIFO stack with search unit.
// ---------------------------------------------------------------------------
package lss_pkg;

    // Stack depth and the cap on found results per search
    localparam int DEPTH       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int MCNT_W      = $clog2(MAX_RESULTS + 1);

    // Operation codes on the input op field
    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    // Result status codes
    localparam logic [2:0] STAT_PUSHED   = 3'd0;
    localparam logic [2:0] STAT_FULL     = 3'd1;
    localparam logic [2:0] STAT_POPPED   = 3'd2;
    localparam logic [2:0] STAT_EMPTY    = 3'd3;
    localparam logic [2:0] STAT_FOUND    = 3'd4;
    localparam logic [2:0] STAT_NOTFOUND = 3'd5;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] operand_value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] item_value;
        logic [4:0]         position;
        logic               last;
    } out_item_t;

    // Classified command handed from front to back
    typedef enum logic [1:0] {
        CMD_PUSH,
        CMD_POP,
        CMD_SEARCH
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic signed [31:0] value;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_SCAN,
        ST_FINISH
    } back_state_t;

    // 1-based position from the top for scan index idx, masked to 5 bits
    function automatic logic [4:0] pos_of(input logic [ADDR_W-1:0] idx);
        int p;
        p = int'(idx) + 1;
        return p[4:0];
    endfunction

endpackage

// File: sv/lss_front.sv
// ---------------------------------------------------------------------------
// lss_front
// Accepts input items, classifies the op code and queues commands for the
// back end in a two-entry queue. Items with an unused op code are dropped.
// ---------------------------------------------------------------------------
module lss_front
    import lss_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_item_t item,
    output logic     cmd_valid,
    output cmd_t     cmd,
    input  logic     cmd_take
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       accept;
    logic       keep;
    cmd_t       cmd_new;

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign accept    = push && !full;

    // Classify the op code; drop the unused one
    always_comb
    begin
        cmd_new.value = item.operand_value;
        cmd_new.kind  = CMD_PUSH;
        keep          = 1'b1;
        unique case (item.op)
            OP_PUSH:   cmd_new.kind = CMD_PUSH;
            OP_POP:    cmd_new.kind = CMD_POP;
            OP_SEARCH: cmd_new.kind = CMD_SEARCH;
            default:   keep = 1'b0;
        endcase
    end

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept && keep)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (cmd_take)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        count_next = count_reg + {1'b0, accept && keep} - {1'b0, cmd_take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold queued commands
    always_ff @(posedge clk)
    begin
        if (accept && keep)
        begin
            slot_reg[wr_ptr_reg] <= cmd_new;
        end
    end

endmodule

// File: sv/lss_back.sv
// ---------------------------------------------------------------------------
// lss_back
// Executes queued commands against the stack memory. Search scans one entry
// a cycle from the top, pausing while a match waits for room to send the held
// one, and holds back one match so the final one can carry the last flag.
// ---------------------------------------------------------------------------
module lss_back
    import lss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  cmd_t      cmd,
    output logic      cmd_take,
    input  logic      res_room,
    output logic      res_wr,
    output out_item_t res_data
);

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_data_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic               mem_we;

    back_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic signed [31:0] key_reg, key_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [4:0]         pend_pos_reg, pend_pos_next;
    logic [MCNT_W-1:0]  mcnt_reg, mcnt_next;

    logic [CNT_W-1:0]   top_idx;
    logic [CNT_W-1:0]   cur_addr_w;
    logic [CNT_W-1:0]   nxt_addr_w;
    logic               match;
    logic               last_entry;

    assign top_idx    = fill_reg - CNT_W'(1);
    assign cur_addr_w = top_idx - CNT_W'(idx_reg);
    assign nxt_addr_w = cur_addr_w - CNT_W'(1);
    assign match      = (rd_data_reg == key_reg);
    assign last_entry = (CNT_W'(idx_reg) == top_idx);

    // Next state, memory control and result generation
    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        idx_next        = idx_reg;
        key_next        = key_reg;
        pend_valid_next = pend_valid_reg;
        pend_pos_next   = pend_pos_reg;
        mcnt_next       = mcnt_reg;
        cmd_take        = 1'b0;
        mem_we          = 1'b0;
        res_wr          = 1'b0;
        res_data        = '0;
        res_data.last   = 1'b1;
        rd_addr         = top_idx[ADDR_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && res_room)
                begin
                    cmd_take = 1'b1;
                    unique case (cmd.kind)
                        CMD_PUSH:
                        begin
                            res_wr = 1'b1;
                            if (fill_reg == CNT_W'(DEPTH))
                            begin
                                res_data.status = STAT_FULL;
                            end
                            else
                            begin
                                mem_we          = 1'b1;
                                fill_next       = fill_reg + CNT_W'(1);
                                res_data.status = STAT_PUSHED;
                            end
                        end
                        CMD_POP:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_wr          = 1'b1;
                                res_data.status = STAT_EMPTY;
                            end
                            else
                            begin
                                fill_next  = top_idx;
                                state_next = ST_POP;
                            end
                        end
                        CMD_SEARCH:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_wr          = 1'b1;
                                res_data.status = STAT_EMPTY;
                            end
                            else
                            begin
                                key_next        = cmd.value;
                                idx_next        = '0;
                                pend_valid_next = 1'b0;
                                mcnt_next       = '0;
                                state_next      = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            cmd_take = 1'b1;
                        end
                    endcase
                end
            end

            ST_POP:
            begin
                // fill has already dropped to the popped entry's index
                rd_addr = fill_reg[ADDR_W-1:0];
                if (res_room)
                begin
                    res_wr              = 1'b1;
                    res_data.status     = STAT_POPPED;
                    res_data.item_value = rd_data_reg;
                    state_next          = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                if (match && pend_valid_reg && !res_room)
                begin
                    // Hold the current entry until the result queue drains
                    rd_addr = cur_addr_w[ADDR_W-1:0];
                end
                else
                begin
                    rd_addr = nxt_addr_w[ADDR_W-1:0];
                    if (match)
                    begin
                        if (pend_valid_reg)
                        begin
                            res_wr            = 1'b1;
                            res_data.status   = STAT_FOUND;
                            res_data.position = pend_pos_reg;
                            res_data.last     = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_pos_next   = pos_of(idx_reg);
                        mcnt_next       = mcnt_reg + MCNT_W'(1);
                    end
                    if (last_entry || (match && mcnt_reg == MCNT_W'(MAX_RESULTS - 1)))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        idx_next = idx_reg + ADDR_W'(1);
                    end
                end
            end

            ST_FINISH:
            begin
                if (res_room)
                begin
                    res_wr = 1'b1;
                    if (pend_valid_reg)
                    begin
                        res_data.status   = STAT_FOUND;
                        res_data.position = pend_pos_reg;
                    end
                    else
                    begin
                        res_data.status = STAT_NOTFOUND;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            mcnt_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            mcnt_reg       <= mcnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        pend_pos_reg <= pend_pos_next;
    end

    // Stack memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[fill_reg[ADDR_W-1:0]] <= cmd.value;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

// File: sv/lss_resq.sv
// ---------------------------------------------------------------------------
// lss_resq
// Two-entry result queue between the back end and the result ports.
// ---------------------------------------------------------------------------
module lss_resq
    import lss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr,
    input  out_item_t wr_data,
    output logic      room,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    out_item_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       rd;

    assign room   = (count_reg != 2'd2);
    assign empty  = (count_reg == 2'd0);
    assign result = slot_reg[rd_ptr_reg];
    assign rd     = pop && !empty;

    // Track occupancy
    always_comb
    begin
        count_next = count_reg + {1'b0, wr} - {1'b0, rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (rd)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // Hold queued results
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: sv/lifo_stack_with_search_unit.sv
// Push runs in the back end straight from idle; pop takes an extra state
// for the registered memory read. Commands and results pass through queues.
// Search: one stored entry compared per cycle from the top, pausing while
// a held match waits for room in the result queue; the single read port of
// the stack memory sets that rate. Reset clears the fill count, queues and
// control state at once; stack contents are left as they are.
// ---------------------------------------------------------------------------
// lifo_stack_with_search_unit
// Bounded LIFO stack of signed 32-bit words with push, pop and key search.
// ---------------------------------------------------------------------------
module lifo_stack_with_search_unit
    import lss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    logic      cmd_valid;
    cmd_t      cmd;
    logic      cmd_take;
    logic      res_room;
    logic      res_wr;
    out_item_t res_data;

    // Accept and classify
    lss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    // Execute against the stack
    lss_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_room  (res_room),
        .res_wr    (res_wr),
        .res_data  (res_data)
    );

    // Queue results for transfer
    lss_resq u_resq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (res_wr),
        .wr_data (res_data),
        .room    (res_room),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    // The back end never writes a result without room for it
    assert property (@(posedge clk) disable iff (!rst_n) res_wr |-> res_room)
        else $error("result written into a full result queue");

    // A command is only taken when one is queued
    assert property (@(posedge clk) disable iff (!rst_n) cmd_take |-> cmd_valid)
        else $error("command taken from an empty command queue");

    // A found result always carries a non-zero position
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status == STAT_FOUND) |-> (result.position != 5'd0))
        else $error("found result with zero position");

endmodule

// File: tb/lifo_stack_with_search_unit_tb.sv
// ---------------------------------------------------------------------------
// lifo_stack_with_search_unit_tb
// Self-checking bench for the LIFO stack with search. A shadow stack works
// out the results of every accepted operation, and each result taken from
// the block is checked field by field against the oldest of them. Stimulus
// is a directed opening (empty and full edges, extreme values, repeated
// keys), random bursts biased towards filling, draining or neither, and a
// closing search of a stack filled with one value. Both sides idle at random.
// ---------------------------------------------------------------------------
module lifo_stack_with_search_unit_tb;

    import lss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Selector value that the block ignores
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic     hold;
        in_item_t op_item;
    } stim_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    in_item_t  item = '0;
    logic      empty;
    logic      pop = 1'b0;
    out_item_t result;

    // Operations waiting to be offered, and results waiting to arrive
    stim_t     stim_q[$];
    out_item_t expected_results[$];

    // Shadow copy of the stack
    logic signed [31:0] shadow_mem [DEPTH];
    int                 shadow_fill = 0;

    int  n_err = 0;
    int  tx_wait = 0;
    int  rx_wait = 0;
    bit  tx_calm = 1'b0;
    bit  rx_calm = 1'b0;
    int  stall_cycles = 0;
    logic signed [31:0] key_pool [3];

    lifo_stack_with_search_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always #10 clk = ~clk;

    // Idle cycles before the next transfer on one side
    function automatic int idle_draw(input bit calm);
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    // Apply one operation to the shadow stack and queue the results it causes
    function automatic void predict_stack_results(input in_item_t op_item);
        out_item_t r;
        int        i;
        int        n_match;
        int        k;
        r = '0;
        r.last = 1'b1;
        case (op_item.op)
            OP_PUSH:
            begin
                if (shadow_fill >= DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    shadow_mem[shadow_fill] = op_item.operand_value;
                    shadow_fill++;
                    r.status = STAT_PUSHED;
                end
                expected_results.push_back(r);
            end
            OP_POP:
            begin
                if (shadow_fill == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    shadow_fill--;
                    r.status = STAT_POPPED;
                    r.item_value = shadow_mem[shadow_fill];
                end
                expected_results.push_back(r);
            end
            OP_SEARCH:
            begin
                if (shadow_fill == 0)
                begin
                    r.status = STAT_EMPTY;
                    expected_results.push_back(r);
                end
                else
                begin
                    // count the reported matches first so the final one carries last
                    n_match = 0;
                    for (i = 0; i < shadow_fill; i++)
                        if (shadow_mem[shadow_fill - 1 - i] == op_item.operand_value
                            && n_match < MAX_RESULTS)
                            n_match++;
                    if (n_match == 0)
                    begin
                        r.status = STAT_NOTFOUND;
                        expected_results.push_back(r);
                    end
                    else
                    begin
                        k = 0;
                        for (i = 0; i < shadow_fill && k < n_match; i++)
                        begin
                            if (shadow_mem[shadow_fill - 1 - i] == op_item.operand_value)
                            begin
                                r.status   = STAT_FOUND;
                                r.position = 5'(i + 1);
                                r.last     = (k == n_match - 1);
                                expected_results.push_back(r);
                                k++;
                            end
                        end
                    end
                end
            end
            default:
            begin
                // unused selector: no result
            end
        endcase
    endfunction

    task automatic queue_op(input logic [1:0] op, input logic signed [31:0] v);
        stim_t s;
        s.hold = 1'b0;
        s.op_item.op = op;
        s.op_item.operand_value = v;
        stim_q.push_back(s);
    endtask

    // Hold the sender until every outstanding result has come back
    task automatic queue_hold();
        stim_t s;
        s = '0;
        s.hold = 1'b1;
        stim_q.push_back(s);
    endtask

    function automatic logic signed [31:0] pick_operand();
        int r;
        r = $urandom_range(0, 9);
        if (r <= 5)
            return key_pool[$urandom_range(0, 2)];
        else if (r == 6)
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    // Driver: offer queued operations, predict on each accepted transfer
    always @(posedge clk or negedge rst_n)
    begin
        stim_t nxt;
        logic  taken;
        if (!rst_n)
        begin
            push <= 1'b0;
            item <= '0;
        end
        else
        begin
            taken = push && !full;
            if (taken)
            begin
                predict_stack_results(item);
                if ($urandom_range(0, 15) == 0)
                    tx_calm = !tx_calm;
                tx_wait = idle_draw(tx_calm);
            end
            if (push && !taken)
            begin
                // hold the offered operation until the block takes it
            end
            else if (tx_wait > 0)
            begin
                push <= 1'b0;
                tx_wait--;
            end
            else if (stim_q.size() == 0)
                push <= 1'b0;
            else if (stim_q[0].hold)
            begin
                push <= 1'b0;
                if (expected_results.size() == 0)
                    void'(stim_q.pop_front());
            end
            else
            begin
                nxt = stim_q.pop_front();
                push <= 1'b1;
                item <= nxt.op_item;
            end
        end
    end

    // Monitor: check each result transfer against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result status=%0d value=%0d pos=%0d last=%0b",
                             $time, result.status, result.item_value, result.position,
                             result.last);
                    n_err++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.status !== want.status || result.item_value !== want.item_value
                        || result.position !== want.position || result.last !== want.last)
                    begin
                        $display("%0t: mismatch expected status=%0d value=%0d pos=%0d last=%0b",
                                 $time, want.status, want.item_value, want.position, want.last);
                        $display("%0t:          actual   status=%0d value=%0d pos=%0d last=%0b",
                                 $time, result.status, result.item_value, result.position,
                                 result.last);
                        n_err++;
                    end
                end
                if ($urandom_range(0, 15) == 0)
                    rx_calm = !rx_calm;
                rx_wait = idle_draw(rx_calm);
            end
            if (rx_wait > 0)
            begin
                pop <= 1'b0;
                rx_wait--;
            end
            else
                pop <= 1'b1;
        end
    end

    // Watchdog: stop the run if no transfer happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL lifo_stack_with_search_unit");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        logic signed [31:0] key;
        logic signed [31:0] v;
        int b;
        int j;
        int r;

        // Directed opening: empty cases, ignored selector, fill to the limit
        key = $urandom;
        queue_op(OP_POP, 32'sd0);
        queue_op(OP_SEARCH, key);
        queue_op(OP_NONE, 32'sh7fff_ffff);
        queue_op(OP_PUSH, key);
        queue_op(OP_PUSH, 32'sh8000_0000);
        queue_op(OP_PUSH, 32'sh7fff_ffff);
        queue_op(OP_PUSH, 32'sh0000_0000);
        queue_op(OP_PUSH, -32'sd1);
        queue_op(OP_PUSH, 32'sh5555_5555);
        queue_op(OP_PUSH, 32'shaaaa_aaaa);
        for (j = 1; j <= 4; j++)
        begin
            queue_op(OP_PUSH, key);
            queue_op(OP_PUSH, 32'(j));
        end
        queue_op(OP_PUSH, key);
        // full refusal, many matches, single match, no match, then pops
        queue_op(OP_PUSH, 32'sh1357_9bdf);
        queue_op(OP_SEARCH, key);
        queue_op(OP_SEARCH, 32'sh8000_0000);
        queue_op(OP_SEARCH, ~key);
        queue_op(OP_POP, 32'sh7fff_ffff);
        queue_op(OP_POP, 32'sh8000_0000);
        queue_hold();

        // Random bursts, in turn biased towards filling, towards draining, and mixed
        key_pool[0] = $urandom;
        key_pool[1] = $urandom;
        key_pool[2] = 32'sd1;
        for (b = 0; b < 6; b++)
        begin
            for (j = 0; j < 8; j++)
            begin
                r = $urandom_range(0, 99);
                if (b % 3 == 0)
                    queue_op(r < 65 ? OP_PUSH : r < 78 ? OP_POP : OP_SEARCH, pick_operand());
                else if (b % 3 == 1)
                    queue_op(r < 15 ? OP_PUSH : r < 70 ? OP_POP : OP_SEARCH, pick_operand());
                else
                    queue_op(r < 35 ? OP_PUSH : r < 60 ? OP_POP :
                             r < 92 ? OP_SEARCH : OP_NONE, pick_operand());
            end
            if (b == 2)
                queue_hold();
        end

        // Empty the stack, fill it with one value, then search for it
        v = pick_operand();
        for (j = 0; j <= DEPTH; j++)
            queue_op(OP_POP, $urandom);
        for (j = 0; j < DEPTH; j++)
            queue_op(OP_PUSH, v);
        queue_op(OP_SEARCH, v);
        queue_op(OP_PUSH, v);
        queue_op(OP_POP, $urandom);
        queue_op(OP_SEARCH, v);

        // Release reset, then wait for all transfers to complete
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (stim_q.size() != 0 || push || expected_results.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);
        if (n_err == 0)
            $display("PASS lifo_stack_with_search_unit");
        else
            $display("FAIL lifo_stack_with_search_unit");
        $finish;
    end

endmodule
